// ===== rtl/rim_pkg.sv =====
// rim_pkg: shared types and constants for the image rotation inverse-map block
// field widths, configuration register indexes, item kinds and internal structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rim_pkg;

    // field widths fixed by the item and register formats
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 8;
    localparam int DIM_W      = 9;
    localparam int COEF_W     = 16;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // register reset values
    localparam logic signed [COEF_W-1:0] COEF_UNITY_RST = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_ZERO_RST  = 16'sd0;
    localparam logic [DIM_W-1:0]         DIM_RST        = 9'd256;

    // colour returned for a source coordinate outside the image
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A       = 3'd0,
        CFG_COEF_B       = 3'd1,
        CFG_COEF_C       = 3'd2,
        CFG_COEF_D       = 3'd3,
        CFG_IMAGE_WIDTH  = 3'd4,
        CFG_IMAGE_HEIGHT = 3'd5
    } t_cfg_idx;

    // configuration as seen by the datapath, sizes already clamped
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
        logic signed [COEF_W-1:0] coef_d;
        logic [DIM_W-1:0]         width;
        logic [DIM_W-1:0]         height;
    } t_cfg;

    // mapped source coordinate and its bounds check
    typedef struct packed {
        logic             in_image;
        logic [DIM_W-1:0] src_col;
        logic [DIM_W-1:0] src_row;
    } t_map_res;

endpackage

`default_nettype wire

// ===== rtl/rim_if.sv =====
// rim_if: valid/ready channel interfaces for pixel items, results and config writes
// depends on rim_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

// input item channel: load or query
interface rim_in_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [rim_pkg::COORD_W-1:0] column;
    logic [rim_pkg::COORD_W-1:0] row;
    logic [rim_pkg::PIX_W-1:0]   red_in;
    logic [rim_pkg::PIX_W-1:0]   green_in;
    logic [rim_pkg::PIX_W-1:0]   blue_in;

    modport source (output valid, kind, column, row, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, kind, column, row, red_in, green_in, blue_in,
                    output ready);
endinterface

// result channel: one rotated output pixel per query
interface rim_out_if;
    logic                     valid;
    logic                     ready;
    logic [rim_pkg::PIX_W-1:0] red_out;
    logic [rim_pkg::PIX_W-1:0] green_out;
    logic [rim_pkg::PIX_W-1:0] blue_out;
    logic                     source_inside;

    modport source (output valid, red_out, green_out, blue_out, source_inside,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, source_inside,
                    output ready);
endinterface

// configuration write channel
interface rim_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rim_pkg::CFG_IDX_W-1:0]  index;
    logic [rim_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/rim_cfg_regs.sv =====
// rim_cfg_regs: matrix coefficient and image size registers
// depends on rim_pkg and rim_cfg_if; sizes are clamped to the store limits
`timescale 1ns / 1ps
`default_nettype none

module rim_cfg_regs #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rim_cfg_if.sink          i_cfg,
    output rim_pkg::t_cfg    o_cfg
);

    logic signed [rim_pkg::COEF_W-1:0] r_coef_a;
    logic signed [rim_pkg::COEF_W-1:0] r_coef_b;
    logic signed [rim_pkg::COEF_W-1:0] r_coef_c;
    logic signed [rim_pkg::COEF_W-1:0] r_coef_d;
    logic [rim_pkg::DIM_W-1:0]         r_width;
    logic [rim_pkg::DIM_W-1:0]         r_height;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= rim_pkg::COEF_UNITY_RST;
            r_coef_b <= rim_pkg::COEF_ZERO_RST;
            r_coef_c <= rim_pkg::COEF_ZERO_RST;
            r_coef_d <= rim_pkg::COEF_UNITY_RST;
            r_width  <= rim_pkg::DIM_RST;
            r_height <= rim_pkg::DIM_RST;
        end else if (i_cfg.valid) begin
            case (rim_pkg::t_cfg_idx'(i_cfg.index))
                rim_pkg::CFG_COEF_A:       r_coef_a <= $signed(i_cfg.data);
                rim_pkg::CFG_COEF_B:       r_coef_b <= $signed(i_cfg.data);
                rim_pkg::CFG_COEF_C:       r_coef_c <= $signed(i_cfg.data);
                rim_pkg::CFG_COEF_D:       r_coef_d <= $signed(i_cfg.data);
                rim_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg.data[rim_pkg::DIM_W-1:0];
                rim_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg.data[rim_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // clamp sizes: zero acts as one, above the limit acts as the limit
    always_comb begin
        o_cfg.coef_a = r_coef_a;
        o_cfg.coef_b = r_coef_b;
        o_cfg.coef_c = r_coef_c;
        o_cfg.coef_d = r_coef_d;
        if (r_width == '0) begin
            o_cfg.width = rim_pkg::DIM_W'(1);
        end else if (int'(r_width) > MAX_WIDTH) begin
            o_cfg.width = rim_pkg::DIM_W'(MAX_WIDTH);
        end else begin
            o_cfg.width = r_width;
        end
        if (r_height == '0) begin
            o_cfg.height = rim_pkg::DIM_W'(1);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            o_cfg.height = rim_pkg::DIM_W'(MAX_HEIGHT);
        end else begin
            o_cfg.height = r_height;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rim_map.sv =====
// rim_map: two-stage inverse-rotation coordinate mapper
// depends on rim_pkg; stage 1 multiplies, stage 2 sums, truncates and bounds-checks
`timescale 1ns / 1ps
`default_nettype none

module rim_map #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic                         i_clk,
    input  wire logic [rim_pkg::COORD_W-1:0]  i_col,
    input  wire logic [rim_pkg::COORD_W-1:0]  i_row,
    input  wire rim_pkg::t_cfg                i_cfg,
    output rim_pkg::t_map_res                 o_res
);

    // centred coordinate, product and sum widths
    localparam int XW = rim_pkg::DIM_W + 1;
    localparam int PW = XW + rim_pkg::COEF_W;
    localparam int SW = PW + 2;
    localparam int unsigned BIAS = (1 << COEF_FRAC_BITS) - 1;

    logic [rim_pkg::COORD_W-1:0] half_w;
    logic [rim_pkg::COORD_W-1:0] half_h;
    logic signed [XW-1:0]        xp;
    logic signed [XW-1:0]        yp;
    logic signed [PW-1:0]        r_p_a;
    logic signed [PW-1:0]        r_p_b;
    logic signed [PW-1:0]        r_p_c;
    logic signed [PW-1:0]        r_p_d;
    logic signed [SW-1:0]        sum_x;
    logic signed [SW-1:0]        sum_y;
    logic signed [SW-1:0]        q_x;
    logic signed [SW-1:0]        q_y;
    logic signed [SW-1:0]        src_x;
    logic signed [SW-1:0]        src_y;
    logic signed [SW-1:0]        width_s;
    logic signed [SW-1:0]        height_s;
    logic signed [SW-1:0]        half_w_s;
    logic signed [SW-1:0]        half_h_s;
    rim_pkg::t_map_res           r_res;

    // centre the coordinate on the integer half sizes
    assign half_w = i_cfg.width[rim_pkg::DIM_W-1:1];
    assign half_h = i_cfg.height[rim_pkg::DIM_W-1:1];
    assign xp = $signed({2'b00, i_col}) - $signed({2'b00, half_w});
    assign yp = $signed({2'b00, i_row}) - $signed({2'b00, half_h});

    // stage 1: four matrix products
    always_ff @(posedge i_clk) begin
        r_p_a <= PW'(xp) * PW'(i_cfg.coef_a);
        r_p_b <= PW'(yp) * PW'(i_cfg.coef_b);
        r_p_c <= PW'(xp) * PW'(i_cfg.coef_c);
        r_p_d <= PW'(yp) * PW'(i_cfg.coef_d);
    end

    // sums, truncated toward zero by biasing negative values before the shift
    assign sum_x = SW'(r_p_a) + SW'(r_p_b);
    assign sum_y = SW'(r_p_c) + SW'(r_p_d);
    assign q_x = (sum_x + (sum_x[SW-1] ? $signed(SW'(BIAS)) : $signed(SW'(0))))
                 >>> COEF_FRAC_BITS;
    assign q_y = (sum_y + (sum_y[SW-1] ? $signed(SW'(BIAS)) : $signed(SW'(0))))
                 >>> COEF_FRAC_BITS;

    // move back from the centre
    assign half_w_s = $signed(SW'(half_w));
    assign half_h_s = $signed(SW'(half_h));
    assign width_s  = $signed(SW'(i_cfg.width));
    assign height_s = $signed(SW'(i_cfg.height));
    assign src_x = q_x + half_w_s;
    assign src_y = q_y + half_h_s;

    // stage 2: bounds check and source coordinate
    always_ff @(posedge i_clk) begin
        r_res.in_image <= (src_x >= $signed(SW'(0))) && (src_x < width_s) &&
                          (src_y >= $signed(SW'(0))) && (src_y < height_s);
        r_res.src_col  <= src_x[rim_pkg::DIM_W-1:0];
        r_res.src_row  <= src_y[rim_pkg::DIM_W-1:0];
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== rtl/rim_frame_store.sv =====
// rim_frame_store: single-port frame memory with registered read data
// depends on rim_pkg for the pixel width; contents undefined until written
`timescale 1ns / 1ps
`default_nettype none

module rim_frame_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_addr,
    input  wire logic [rim_pkg::RGB_W-1:0] i_wdata,
    output logic [rim_pkg::RGB_W-1:0]      o_rdata
);

    logic [rim_pkg::RGB_W-1:0] r_mem [DEPTH];
    logic [rim_pkg::RGB_W-1:0] r_rdata;

    // one access per cycle, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/image_rotate_inverse_map_top.sv =====
// image_rotate_inverse_map_top: nearest-neighbour rotation by inverse mapping
// depends on rim_pkg, rim_if, rim_cfg_regs, rim_map and rim_frame_store
// Items are handled one at a time. A load is registered on acceptance and written to the
// frame store in the load state (address multiply there); a load outside the image is
// dropped. A query passes from acceptance to its result in the output register through
// the coefficient multiply, the sum and truncate with bounds check, the address multiply
// with the frame store read, and the registered read data. No new item is accepted until
// the previous one is finished; a query also waits while a previous result sits untaken
// in the output register. The frame store holds MAX_WIDTH*MAX_HEIGHT pixels at
// row*width+column and has no clearing pass: a query must only hit pixels that were
// loaded. Coefficients are signed with COEF_FRAC_BITS fraction bits; configuration is
// to be written while idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module image_rotate_inverse_map_top #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int COEF_FRAC_BITS = 14
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rim_in_if.sink    i_in,
    rim_out_if.source o_out,
    rim_cfg_if.sink   i_cfg
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_SUM,
        ST_ADDR,
        ST_RESULT
    } t_state;

    t_state                        r_state;
    t_state                        n_state;
    logic [rim_pkg::COORD_W-1:0]   r_col;
    logic [rim_pkg::COORD_W-1:0]   n_col;
    logic [rim_pkg::COORD_W-1:0]   r_row;
    logic [rim_pkg::COORD_W-1:0]   n_row;
    logic [rim_pkg::RGB_W-1:0]     r_pix;
    logic [rim_pkg::RGB_W-1:0]     n_pix;
    logic                          r_load_ok;
    logic                          n_load_ok;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [rim_pkg::RGB_W-1:0]     r_out_pix;
    logic [rim_pkg::RGB_W-1:0]     n_out_pix;
    logic                          r_out_inside;
    logic                          n_out_inside;

    rim_pkg::t_cfg                 cfg;
    rim_pkg::t_map_res             map_res;
    logic                          in_acc;
    logic [rim_pkg::DIM_W-1:0]     addr_col;
    logic [rim_pkg::DIM_W-1:0]     addr_row;
    logic [AW-1:0]                 mem_addr;
    logic                          mem_we;
    logic                          mem_re;
    logic [rim_pkg::RGB_W-1:0]     mem_rdata;

    // configuration registers
    rim_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // coordinate mapper, fed from the held query coordinate
    rim_map #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_map (
        .i_clk (i_clk),
        .i_col (r_col),
        .i_row (r_row),
        .i_cfg (cfg),
        .o_res (map_res)
    );

    // frame store address: load position or mapped source position
    assign addr_col = (r_state == ST_LOAD) ? {1'b0, r_col} : map_res.src_col;
    assign addr_row = (r_state == ST_LOAD) ? {1'b0, r_row} : map_res.src_row;
    assign mem_addr = AW'(addr_row) * AW'(cfg.width) + AW'(addr_col);
    assign mem_we   = (r_state == ST_LOAD) && r_load_ok;
    assign mem_re   = (r_state == ST_ADDR) && map_res.in_image;

    rim_frame_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (r_pix),
        .o_rdata (mem_rdata)
    );

    // handshake
    assign i_in.ready          = (r_state == ST_IDLE);
    assign in_acc              = i_in.valid && i_in.ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.red_out       = r_out_pix[3*rim_pkg::PIX_W-1:2*rim_pkg::PIX_W];
    assign o_out.green_out     = r_out_pix[2*rim_pkg::PIX_W-1:rim_pkg::PIX_W];
    assign o_out.blue_out      = r_out_pix[rim_pkg::PIX_W-1:0];
    assign o_out.source_inside = r_out_inside;

    // sequencer next state and output register
    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_row        = r_row;
        n_pix        = r_pix;
        n_load_ok    = r_load_ok;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pix    = r_out_pix;
        n_out_inside = r_out_inside;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_col     = i_in.column;
                    n_row     = i_in.row;
                    n_pix     = {i_in.red_in, i_in.green_in, i_in.blue_in};
                    n_load_ok = ({1'b0, i_in.column} < cfg.width) &&
                                ({1'b0, i_in.row} < cfg.height);
                    n_state   = (i_in.kind == rim_pkg::KIND_QUERY) ? ST_MUL : ST_LOAD;
                end
            end
            ST_LOAD:   n_state = ST_IDLE;
            ST_MUL:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_ADDR;
            ST_ADDR:   n_state = ST_RESULT;
            ST_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_inside = map_res.in_image;
                    n_out_pix    = map_res.in_image ? mem_rdata :
                                   {rim_pkg::PIX_WHITE, rim_pkg::PIX_WHITE,
                                    rim_pkg::PIX_WHITE};
                    n_state      = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_col        <= n_col;
        r_row        <= n_row;
        r_pix        <= n_pix;
        r_load_ok    <= n_load_ok;
        r_out_pix    <= n_out_pix;
        r_out_inside <= n_out_inside;
    end

    // a query reaches the result stage after the multiply, sum and address states
    a_query_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind == rim_pkg::KIND_QUERY) |=> ##3 (r_state == ST_RESULT))
        else $error("query did not reach the result stage on time");

    // a store write only ever lands inside the configured image
    a_write_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (({1'b0, r_col} < cfg.width) && ({1'b0, r_row} < cfg.height)))
        else $error("frame store written outside the image");

    // an outside result carries white on every channel
    a_outside_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.source_inside) |->
        (o_out.red_out == rim_pkg::PIX_WHITE && o_out.green_out == rim_pkg::PIX_WHITE
         && o_out.blue_out == rim_pkg::PIX_WHITE))
        else $error("outside result is not white");

endmodule

`default_nettype wire
